>>> hw/rtl/assert_macros.svh
// assertion macros for the rtl files, included by bad_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property holds at every clock edge out of reset
`define BAD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define BAD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define BAD_ASSERT(lbl, clk, rst_n, prop, msg)
`define BAD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> hw/rtl/bad_pkg.sv
package bad_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned CountW  = 16;
  localparam int unsigned SumW    = 32;
  localparam int unsigned MeanW   = 32;
  localparam int unsigned FracW   = 16;
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QPtrW   = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW   = $clog2(QDepth + 1);
  localparam int unsigned IterW   = $clog2(MeanW);

  // one closed bin waiting for its division
  typedef struct packed {
    logic [SumW-1:0]   sum;
    logic [CountW-1:0] count;
    logic              partial;
    logic              final_res;
  } job_t;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> hw/rtl/bad_if.sv
interface bad_in_if;
  import bad_pkg::*;
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] sample;
  logic               last_value;
  modport source (output valid, output sample, output last_value, input ready);
  modport sink   (input valid, input sample, input last_value, output ready);
endinterface

interface bad_out_if;
  import bad_pkg::*;
  logic              valid;
  logic              ready;
  logic [MeanW-1:0]  mean;
  logic              partial;
  logic [CountW-1:0] bin_count;
  logic              final_res;
  modport source (output valid, output mean, output partial, output bin_count,
                  output final_res, input ready);
  modport sink   (input valid, input mean, input partial, input bin_count,
                  input final_res, output ready);
endinterface

>>> hw/rtl/bad_front.sv
module bad_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bad_pkg::CountW-1:0]   cfg_wdata_i,
  bad_in_if.sink                       in_i,
  input  bad_pkg::q_status_t           q_status_i,
  output logic                         push_o,
  output bad_pkg::job_t                job_o
);
  import bad_pkg::*;

  logic [CountW-1:0] bin_size_q;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [CountW-1:0] pos_q, pos_d;
  logic [CountW-1:0] size;
  logic              accept, full, close;

  assign in_i.ready = !q_status_i.full;
  assign accept     = in_i.valid && in_i.ready;

  // zero bin size behaves as one
  assign size  = (bin_size_q == '0) ? CountW'(1) : bin_size_q;
  assign sum_d = sum_q + SumW'(in_i.sample);
  assign pos_d = pos_q + CountW'(1);
  assign full  = pos_d >= size;
  assign close = full || in_i.last_value;

  assign push_o          = accept && close;
  assign job_o.sum       = sum_d;
  assign job_o.count     = pos_d;
  assign job_o.partial   = !full;
  assign job_o.final_res = in_i.last_value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_size_q <= CountW'(1);
      sum_q      <= '0;
      pos_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        bin_size_q <= cfg_wdata_i;
      end
      if (accept) begin
        if (close) begin
          sum_q <= '0;
          pos_q <= '0;
        end else begin
          sum_q <= sum_d;
          pos_q <= pos_d;
        end
      end
    end
  end

endmodule

>>> hw/rtl/bad_queue.sv
module bad_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bad_pkg::job_t      job_i,
  input  logic               pop_i,
  output bad_pkg::job_t      job_o,
  output bad_pkg::q_status_t q_status_o
);
  import bad_pkg::*;

  job_t             entry_q [QDepth];
  logic [QPtrW-1:0] wptr_q, rptr_q;
  logic [QCntW-1:0] cnt_q;

  function automatic logic [QPtrW-1:0] ptr_inc(input logic [QPtrW-1:0] p);
    ptr_inc = (p == QPtrW'(QDepth - 1)) ? '0 : p + QPtrW'(1);
  endfunction

  assign q_status_o.full  = cnt_q == QCntW'(QDepth);
  assign q_status_o.empty = cnt_q == '0;
  assign job_o            = entry_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= ptr_inc(wptr_q);
      end
      if (pop_i) begin
        rptr_q <= ptr_inc(rptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

endmodule

>>> hw/rtl/bad_back.sv
`include "assert_macros.svh"

module bad_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bad_pkg::q_status_t q_status_i,
  input  bad_pkg::job_t      job_i,
  output logic               pop_o,
  bad_out_if.source          out_o
);
  import bad_pkg::*;

  typedef enum logic [1:0] {StIdle, StBusy, StDone} state_e;

  state_e            state_q;
  logic [IterW-1:0]  iter_q;
  logic [CountW-1:0] rem_q;
  logic [CountW-1:0] div_q;
  logic [MeanW-1:0]  quo_q;
  logic              partial_q, final_q;

  logic [CountW:0]   rem_sh, trial;
  logic              ge;
  logic [CountW-1:0] rem_n;
  logic [MeanW-1:0]  quo_n;
  logic              last_iter;

  assign pop_o = (state_q == StIdle) && !q_status_i.empty;

  // one restoring step: quotient bit per cycle
  assign rem_sh    = {rem_q, quo_q[MeanW-1]};
  assign trial     = rem_sh - {1'b0, div_q};
  assign ge        = rem_sh >= {1'b0, div_q};
  assign rem_n     = ge ? trial[CountW-1:0] : rem_sh[CountW-1:0];
  assign quo_n     = {quo_q[MeanW-2:0], ge};
  assign last_iter = iter_q == IterW'(MeanW - 1);

  assign out_o.valid     = state_q == StDone;
  assign out_o.mean      = quo_q;
  assign out_o.partial   = partial_q;
  assign out_o.bin_count = div_q;
  assign out_o.final_res = final_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      iter_q    <= '0;
      rem_q     <= '0;
      div_q     <= '0;
      quo_q     <= '0;
      partial_q <= 1'b0;
      final_q   <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (pop_o) begin
            // upper quotient bits are zero since the mean stays below 2^32,
            // so the remainder starts as the high half of the sum
            rem_q     <= job_i.sum[SumW-1:SumW-CountW];
            quo_q     <= {job_i.sum[SumW-CountW-1:0], FracW'(0)};
            div_q     <= job_i.count;
            partial_q <= job_i.partial;
            final_q   <= job_i.final_res;
            iter_q    <= '0;
            state_q   <= StBusy;
          end
        end
        StBusy: begin
          rem_q  <= rem_n;
          quo_q  <= quo_n;
          iter_q <= iter_q + IterW'(1);
          if (last_iter) begin
            state_q <= StDone;
          end
        end
        StDone: begin
          if (out_o.ready) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  `BAD_ASSERT(a_rem_below_div, clk_i, rst_ni, (state_q != StBusy) || (rem_q < div_q), "remainder not below divisor")
  `BAD_ASSERT_NEXT(a_last_iter_done, clk_i, rst_ni, (state_q == StBusy) && last_iter, out_o.valid, "division did not finish")
  `BAD_ASSERT(a_valid_from_busy, clk_i, rst_ni, !$rose(out_o.valid) || ($past(state_q) == StBusy), "result shown without division")

endmodule

>>> hw/rtl/bin_average_decimator_top.sv
// channel  | role   | transaction payload
// in_i     | sink   | sample[15:0], last_value
// out_o    | source | mean[31:0] q16.16, partial, bin_count[15:0], final_res
// cfg      | write  | cfg_we_i, cfg_wdata_i = bin_size[15:0]
//
// an input transaction is taken every cycle while the bin queue has room
// each closed bin is loaded into the divider, divided one quotient bit at a time,
// then held in the output register; no new bin loads until the result is taken
// reset clears the bin state, the queue and the divider; bin_size resets to 1
// a stalled output holds the divider, the queue then fills and stops input

module bin_average_decimator_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bad_pkg::CountW-1:0] cfg_wdata_i,
  bad_in_if.sink                     in_i,
  bad_out_if.source                  out_o
);
  import bad_pkg::*;

  // front to queue
  logic      push;
  job_t      push_job;
  // queue to back
  logic      pop;
  job_t      head_job;
  q_status_t q_status;

  // front: sums samples, counts positions, closes bins
  bad_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .q_status_i  (q_status),
    .push_o      (push),
    .job_o       (push_job)
  );

  // short queue of closed bins decouples the accumulator from the divider
  bad_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .job_i      (push_job),
    .pop_i      (pop),
    .job_o      (head_job),
    .q_status_o (q_status)
  );

  // back: bit-serial divide of sum * 2^16 by count, result register
  bad_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_status_i (q_status),
    .job_i      (head_job),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule

>>> tb/bin_average_decimator_top_tb.sv
`timescale 1ns / 100ps

module bin_average_decimator_top_tb;
  import bad_pkg::*;

  localparam int unsigned ClkPeriod   = 20;
  localparam int unsigned SettleCycles = 40;   // load plus every divider step, with margin
  localparam int unsigned StallLimit  = 2000;  // cycles without any transaction
  localparam int unsigned RandomItems = 400;
  localparam int unsigned QuietFrom   = 300;   // no idling from here on
  localparam logic [CountW-1:0] MaxBin = '1;
  localparam logic [SampleW-1:0] MaxSample = '1;

  // one expected or observed bin mean
  typedef struct packed {
    logic [MeanW-1:0]  mean;
    logic              partial;
    logic [CountW-1:0] bin_count;
    logic              final_res;
  } bin_mean_t;

  // predicts bin means from accepted samples and checks the results against them
  class bin_mean_scoreboard;
    logic [CountW-1:0] bin_size;
    logic [SumW-1:0]   bin_sum;
    logic [CountW-1:0] bin_fill;
    bin_mean_t         means_due[$];
    int unsigned       samples_taken;
    int unsigned       means_checked;
    int unsigned       full_bins;
    int unsigned       partial_bins;
    int unsigned       failures;

    function new();
      bin_size      = 1;
      bin_sum       = '0;
      bin_fill      = '0;
      samples_taken = 0;
      means_checked = 0;
      full_bins     = 0;
      partial_bins  = 0;
      failures      = 0;
    endfunction

    function void set_bin_size(logic [CountW-1:0] value);
      bin_size = value;
    endfunction

    function int unsigned pending();
      return means_due.size();
    endfunction

    function void note_sample(logic [SampleW-1:0] sample, logic last_value);
      logic [CountW-1:0]    eff_size;
      logic [SumW+FracW-1:0] scaled;
      logic                 is_full;
      bin_mean_t            due;
      samples_taken++;
      eff_size = (bin_size == '0) ? CountW'(1) : bin_size;
      bin_sum  = bin_sum + SumW'(sample);
      bin_fill = bin_fill + CountW'(1);
      is_full  = (bin_fill >= eff_size);
      if (is_full || last_value) begin
        scaled        = {bin_sum, {FracW{1'b0}}};
        scaled        = scaled / bin_fill;
        due.mean      = scaled[MeanW-1:0];
        due.partial   = !is_full;
        due.bin_count = bin_fill;
        due.final_res = last_value;
        means_due.push_back(due);
        if (is_full) full_bins++;
        else partial_bins++;
        bin_sum  = '0;
        bin_fill = '0;
      end
    endfunction

    function void check_mean(bin_mean_t seen);
      bin_mean_t due;
      means_checked++;
      if (means_due.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: unexpected result mean=%h partial=%b count=%0d final=%b",
                   $realtime, seen.mean, seen.partial, seen.bin_count, seen.final_res);
        return;
      end
      due = means_due.pop_front();
      if (seen.mean !== due.mean || seen.partial !== due.partial ||
          seen.bin_count !== due.bin_count || seen.final_res !== due.final_res) begin
        failures++;
        if (failures <= 10) begin
          $display("%0t: result mismatch exp mean=%h partial=%b count=%0d final=%b",
                   $realtime, due.mean, due.partial, due.bin_count, due.final_res);
          $display("%0t: result mismatch got mean=%h partial=%b count=%0d final=%b",
                   $realtime, seen.mean, seen.partial, seen.bin_count, seen.final_res);
        end
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CountW-1:0]   cfg_wdata_i;

  bad_in_if  in_if ();
  bad_out_if out_if ();

  bin_average_decimator_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  bin_mean_scoreboard sb = new();

  bit          idle_on = 1'b1;   // random gaps on both channels while set
  int unsigned out_stall_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned random_sent = 0;
  int unsigned size_writes = 0;

  // free-running clock
  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // every input known from time zero
  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    in_if.valid       = 1'b0;
    in_if.sample      = '0;
    in_if.last_value  = 1'b0;
    out_if.ready      = 1'b0;
  end

  // result side back-pressure: stall bursts of random length while idling is on
  always @(negedge clk_i) begin
    if (out_stall_left > 0) begin
      out_stall_left--;
      out_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall_left = $urandom_range(1, 12) - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // every result transaction goes to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_mean('{mean: out_if.mean, partial: out_if.partial,
                      bin_count: out_if.bin_count, final_res: out_if.final_res});
  end

  // watchdog: too long without a transaction on either channel ends the run
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("timeout: no transaction for %0d cycles", StallLimit);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one sample transaction; valid stays high straight into the next item unless a gap is drawn
  task automatic send_sample(input logic [SampleW-1:0] sample, input logic last_value);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_if.valid      <= 1'b1;
    in_if.sample     <= sample;
    in_if.last_value <= last_value;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_sample(sample, last_value);
  endtask

  // stop sending, wait for every pending mean, then let the divider settle
  task automatic drain_means();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // bin size written only with the block idle
  task automatic write_bin_size(input logic [CountW-1:0] value);
    drain_means();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_bin_size(value);
    size_writes++;
  endtask

  // mostly random coverage values, with the extremes turning up often
  function automatic logic [SampleW-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return MaxSample;
      default: return SampleW'($urandom_range(0, 65535));
    endcase
  endfunction

  // one random bin size followed by a few vectors; some left open so the next size lands mid-bin
  task automatic run_random_phase();
    logic [CountW-1:0] size;
    int unsigned       eff_size;
    int unsigned       vectors;
    int unsigned       len;
    bit                leave_open;
    case ($urandom_range(0, 9))
      0:       size = '0;
      1:       size = MaxBin;
      2:       size = CountW'($urandom_range(11, 60));
      default: size = CountW'($urandom_range(1, 10));
    endcase
    write_bin_size(size);
    eff_size = (size == '0) ? 1 : size;
    vectors  = $urandom_range(1, 3);
    for (int v = 0; v < vectors; v++) begin
      if (size == MaxBin) len = $urandom_range(1, 20);
      else len = $urandom_range(1, (eff_size * 3 > 60) ? 60 : eff_size * 3);
      leave_open = ($urandom_range(0, 7) == 0);
      for (int k = 0; k < len; k++) begin
        send_sample(pick_sample(), (k == len - 1) && !leave_open);
        random_sent++;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset bin size of one: every sample is its own mean
    send_sample('0, 1'b0);
    send_sample(MaxSample, 1'b0);
    send_sample(16'h1234, 1'b1);

    // full bins of four, a partial bin flushed by last, a full bin closed by last
    write_bin_size(16'd4);
    repeat (4) send_sample(MaxSample, 1'b0);
    send_sample(16'd1, 1'b0);
    send_sample(16'd2, 1'b0);
    send_sample(16'd3, 1'b1);
    for (int k = 0; k < 4; k++) send_sample(pick_sample(), k == 3);

    // zero bin size behaves as one
    write_bin_size('0);
    send_sample(16'd5, 1'b0);
    send_sample(MaxSample, 1'b1);

    // bin size lowered with five values already in the bin: closes full at six
    write_bin_size(16'd8);
    for (int k = 0; k < 5; k++) send_sample(pick_sample(), 1'b0);
    write_bin_size(16'd3);
    send_sample(16'd7, 1'b0);
    send_sample(16'd9, 1'b1);   // a last on its own still gives a mean

    // largest bin size with a short vector: partial flush
    write_bin_size(MaxBin);
    send_sample(MaxSample, 1'b0);
    send_sample(MaxSample, 1'b0);
    send_sample('0, 1'b1);

    // random phases, idling switched off for the tail of the run
    while (random_sent < QuietFrom) run_random_phase();
    idle_on = 1'b0;
    while (random_sent < RandomItems) run_random_phase();

    drain_means();
    if (sb.pending() != 0) begin
      sb.failures++;
      $display("%0d expected means never arrived", sb.pending());
    end

    $display("covered %0d samples, %0d means (%0d full bins, %0d partial bins)",
             sb.samples_taken, sb.means_checked, sb.full_bins, sb.partial_bins);
    $display("bin size written %0d times, %0d mismatches", size_writes, sb.failures);
    if (sb.failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> bin_average_decimator_top.f
+incdir+hw/rtl
hw/rtl/bad_pkg.sv
hw/rtl/bad_if.sv
hw/rtl/bad_front.sv
hw/rtl/bad_queue.sv
hw/rtl/bad_back.sv
hw/rtl/bin_average_decimator_top.sv
tb/bin_average_decimator_top_tb.sv
